/* design/alm_pkg.sv */
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types and constants for the array-backed linked list manager.
// ----------------------------------------------------------------------------
`default_nettype none

package alm_pkg;

	localparam int SLOTS      = 8;
	localparam int IDX_W      = 3;
	localparam int VALUE_BITS = 16;
	localparam int STEP_W     = $clog2(SLOTS + 2);

	typedef enum logic [1:0] {
		FN_INSERT,
		FN_UPDATE,
		FN_DELETE,
		FN_NOP
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_NOT_FOUND,
		STAT_FULL,
		STAT_HEAD
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_WALK,
		S_INS_SCAN,
		S_UPD_WALK,
		S_DEL_START,
		S_DEL_WALK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic    in_ready;
		logic    load;
		logic    done;
		status_t res_status;
		logic    res_cur;
		logic    adv_cur;
		logic    adv_prev;
		logic    inc_steps;
		logic    scan_inc;
		logic    wr_insert;
		logic    wr_update;
		logic    wr_delete;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		func_t in_func;
		logic  cur_valid;
		logic  cur_is_node;
		logic  node_is_head;
		logic  steps_at_limit;
		logic  steps_over;
		logic  cand_free;
		logic  scan_last;
		logic  out_free;
	} stat_t;

endpackage

`default_nettype wire

/* design/alm_ctrl.sv */
// ----------------------------------------------------------------------------
// alm_ctrl
// Sequencer for insert, update and delete walks over the slot store.
// ----------------------------------------------------------------------------
`default_nettype none

module alm_ctrl import alm_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (stat.in_func)
						FN_INSERT: state_d = S_INS_WALK;
						FN_UPDATE: state_d = S_UPD_WALK;
						FN_DELETE: state_d = S_DEL_START;
						default:   state_d = S_FINISH;
					endcase
				end
			end
			S_INS_WALK: begin
				if (!stat.cur_valid) begin
					state_d = S_INS_SCAN;
				end else if (stat.steps_at_limit) begin
					state_d = S_FINISH;
				end
			end
			S_INS_SCAN: begin
				if (stat.cand_free || stat.scan_last) begin
					state_d = S_FINISH;
				end
			end
			S_UPD_WALK: begin
				if (!stat.cur_valid || stat.steps_over || stat.cur_is_node) begin
					state_d = S_FINISH;
				end
			end
			S_DEL_START: begin
				if (stat.node_is_head || !stat.cur_valid) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_DEL_WALK;
				end
			end
			S_DEL_WALK: begin
				if (!stat.cur_valid || stat.steps_over || stat.cur_is_node) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_status = STAT_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = in_valid;
			end
			S_INS_WALK: begin
				if (stat.cur_valid) begin
					if (stat.steps_at_limit) begin
						cmd.done       = 1'b1;
						cmd.res_status = STAT_FULL;
					end else begin
						cmd.adv_cur   = 1'b1;
						cmd.inc_steps = 1'b1;
					end
				end
			end
			S_INS_SCAN: begin
				if (stat.cand_free) begin
					cmd.wr_insert  = 1'b1;
					cmd.done       = 1'b1;
					cmd.res_status = STAT_OK;
					cmd.res_cur    = 1'b1;
				end else if (stat.scan_last) begin
					cmd.done       = 1'b1;
					cmd.res_status = STAT_FULL;
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			S_UPD_WALK: begin
				if (!stat.cur_valid || stat.steps_over) begin
					cmd.done       = 1'b1;
					cmd.res_status = STAT_NOT_FOUND;
				end else if (stat.cur_is_node) begin
					cmd.wr_update  = 1'b1;
					cmd.done       = 1'b1;
					cmd.res_status = STAT_OK;
					cmd.res_cur    = 1'b1;
				end else begin
					cmd.adv_cur   = 1'b1;
					cmd.inc_steps = 1'b1;
				end
			end
			S_DEL_START: begin
				if (stat.node_is_head) begin
					cmd.done       = 1'b1;
					cmd.res_status = STAT_HEAD;
				end else if (!stat.cur_valid) begin
					cmd.done       = 1'b1;
					cmd.res_status = STAT_NOT_FOUND;
				end else begin
					cmd.adv_cur = 1'b1;
				end
			end
			S_DEL_WALK: begin
				if (!stat.cur_valid || stat.steps_over) begin
					cmd.done       = 1'b1;
					cmd.res_status = STAT_NOT_FOUND;
				end else if (stat.cur_is_node) begin
					cmd.wr_delete  = 1'b1;
					cmd.done       = 1'b1;
					cmd.res_status = STAT_OK;
					cmd.res_cur    = 1'b1;
				end else begin
					cmd.adv_cur   = 1'b1;
					cmd.adv_prev  = 1'b1;
					cmd.inc_steps = 1'b1;
				end
			end
			S_FINISH: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/alm_dpath.sv */
// ----------------------------------------------------------------------------
// alm_dpath
// Slot store, walk pointers, free-slot scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module alm_dpath import alm_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [IDX_W-1:0]      cfg_wdata,
	input  wire [23:0]           in_word,
	input  wire                  out_ready,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic                 out_valid,
	output logic [7:0]           out_word
);

	logic [SLOTS-1:0]      valid_q;
	logic [VALUE_BITS-1:0] value_q [SLOTS];
	logic [IDX_W-1:0]      next_q  [SLOTS];

	logic [IDX_W-1:0]      head_q;
	logic [IDX_W-1:0]      node_q;
	logic [VALUE_BITS-1:0] data_q;
	logic [IDX_W-1:0]      start_q;
	logic [IDX_W-1:0]      cur_q;
	logic [IDX_W-1:0]      prev_q;
	logic [STEP_W-1:0]     steps_q;
	logic [IDX_W-1:0]      scan_q;
	status_t               pend_status_q;
	logic [IDX_W-1:0]      pend_index_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [IDX_W-1:0]      out_index_q;

	logic [IDX_W:0]        cand_sum;
	logic [IDX_W-1:0]      cand;
	logic [IDX_W-1:0]      cur_next;

	assign cand_sum = {1'b0, start_q} + {1'b0, scan_q};
	assign cand     = (cand_sum >= (IDX_W+1)'(SLOTS)) ?
		IDX_W'(cand_sum - (IDX_W+1)'(SLOTS)) : cand_sum[IDX_W-1:0];
	assign cur_next = next_q[cur_q];

	always_comb begin
		stat.in_func        = func_t'(in_word[1:0]);
		stat.cur_valid      = valid_q[cur_q];
		stat.cur_is_node    = (cur_q == node_q);
		stat.node_is_head   = (node_q == head_q);
		stat.steps_at_limit = (steps_q >= STEP_W'(SLOTS));
		stat.steps_over     = (steps_q > STEP_W'(SLOTS));
		stat.cand_free      = !valid_q[cand] && (cand != cur_q);
		stat.scan_last      = (scan_q == IDX_W'(SLOTS - 1));
		stat.out_free       = !out_valid_q || out_ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				head_q <= cfg_wdata;
			end
			if (cmd.wr_insert) begin
				valid_q[cur_q] <= 1'b1;
			end
			if (cmd.wr_delete) begin
				valid_q[cur_q] <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (cmd.wr_insert) begin
			value_q[cur_q] <= data_q;
			next_q[cur_q]  <= cand;
		end
		if (cmd.wr_update) begin
			value_q[cur_q] <= data_q;
		end
		if (cmd.wr_delete) begin
			next_q[prev_q] <= cur_next;
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q        <= in_word[4:2];
			data_q        <= in_word[20:5];
			start_q       <= in_word[23:21];
			cur_q         <= head_q;
			prev_q        <= head_q;
			steps_q       <= '0;
			scan_q        <= '0;
			pend_status_q <= STAT_OK;
			pend_index_q  <= '0;
		end else begin
			if (cmd.adv_cur) begin
				cur_q <= cur_next;
			end
			if (cmd.adv_prev) begin
				prev_q <= cur_q;
			end
			if (cmd.inc_steps) begin
				steps_q <= steps_q + STEP_W'(1);
			end
			if (cmd.scan_inc) begin
				scan_q <= scan_q + IDX_W'(1);
			end
			if (cmd.done) begin
				pend_status_q <= cmd.res_status;
				pend_index_q  <= cmd.res_cur ? cur_q : '0;
			end
		end
		if (cmd.out_load) begin
			out_status_q <= pend_status_q;
			out_index_q  <= pend_index_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = {3'b000, out_index_q, out_status_q};

endmodule

`default_nettype wire

/* design/array_linked_list_manager.sv */
// ----------------------------------------------------------------------------
// array_linked_list_manager
// Singly linked list kept in a fixed store of slots: insert, update, delete.
// ----------------------------------------------------------------------------
// channel   dir  handshake                      word
// s_axis    in   s_axis_tvalid / s_axis_tready  func, node_index, data_value, start_slot
// m_axis    out  m_axis_tvalid / m_axis_tready  status, result_index
// cfg       in   cfg_we                         head_index
//
// One word at a time. A no-op goes straight to the result; an update follows
// links from the head; a delete on the head returns a head status, else it
// follows links past the first; an insert follows links to an empty slot, then scans slots.
// The walk advances one link per cycle through the next-index store.
// Reset empties every slot at once (valid flops) and sets head to 0.
// A finished result is held in the output register; a stalled output
// holds the sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module array_linked_list_manager import alm_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] func, [4:2] node_index, [20:5] data_value, [23:21] start_slot
	input  wire  [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [1:0] status, [4:2] result_index, [7:5] zero
	output logic [7:0]  m_axis_tdata,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	alm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	alm_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_word   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_word  (m_axis_tdata)
	);

	assign s_axis_tready = cmd.in_ready;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second word accepted while busy");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten before taken");

	a_error_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] != STAT_OK) |-> (m_axis_tdata[4:2] == 3'd0))
		else $error("error result with nonzero index");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_insert, cmd.wr_update, cmd.wr_delete, cmd.load}))
		else $error("conflicting store commands");

endmodule

`default_nettype wire
